// ----- hdl/vector_arith_unit_core_macros.svh -----
// Assertion macros used by the vector unit checker module.
// Depends on nothing; included by the checker file.
`ifndef VECTOR_ARITH_UNIT_CORE_MACROS_SVH
`define VECTOR_ARITH_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define VAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector unit check failed");

// Next-cycle implication, disabled while reset is low.
`define VAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector unit check failed");

`endif

// ----- hdl/vau_pkg.sv -----
// Types, constants and the clamp function of the vector arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vau_pkg;

    localparam int SQ_STEPS = 32;   // one root bit per stage
    localparam int DV_STEPS = 48;   // one quotient bit per stage
    localparam int LANES    = 3;

    typedef enum logic [2:0] {
        CMD_MAG  = 3'd0,
        CMD_NORM = 3'd1,
        CMD_ADD  = 3'd2,
        CMD_SUB  = 3'd3,
        CMD_NEG  = 3'd4,
        CMD_MUL  = 3'd5,
        CMD_DIV  = 3'd6,
        CMD_NONE = 3'd7
    } t_cmd;

    // Data that travels alongside the root and divide pipelines.
    typedef struct packed {
        t_cmd                     cmd;
        logic [LANES-1:0]         neg_a;
        logic                     neg_s;
        logic [LANES-1:0][31:0]   abs_a;
        logic [31:0]              abs_s;
        logic [LANES-1:0][32:0]   sum;     // signed add / sub / negate result
        logic [LANES-1:0][47:0]   prod;    // |a*s| >> 16
        logic [31:0]              mag;     // filled by the root pipeline
    } t_side;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_clamp;

    // Sign and magnitude to saturated two's complement.
    function automatic t_clamp clamp_sm(input logic neg, input logic [47:0] mag);
        t_clamp res;
        res.sat = 1'b0;
        if (!neg) begin
            if (mag > 48'h0000_7FFF_FFFF) begin
                res.sat = 1'b1;
                res.val = 32'h7FFF_FFFF;
            end else begin
                res.val = mag[31:0];
            end
        end else begin
            if (mag > 48'h0000_8000_0000) begin
                res.sat = 1'b1;
                res.val = 32'h8000_0000;
            end else begin
                res.val = 32'(48'd0 - mag);
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/vau_ifs.sv -----
// Request and result channel interfaces of the vector arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface vau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic        three_d;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scalar;
    modport source (output valid, cmd, three_d, ax, ay, az, bx, by, bz, scalar,
                    input ready);
    modport sink   (input valid, cmd, three_d, ax, ay, az, bx, by, bz, scalar,
                    output ready);
endinterface

interface vau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic [31:0] magnitude;
    logic        div_zero;
    logic        saturated;
    modport source (output valid, rx, ry, rz, magnitude, div_zero, saturated,
                    input ready);
    modport sink   (input valid, rx, ry, rz, magnitude, div_zero, saturated,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/vau_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, side data carried along.
// Depends on vau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vau_sqrt
    import vau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_rad,
    input  wire t_side       i_side,
    output logic             o_vld,
    output t_side            o_side
);

    logic              r_vld  [1:SQ_STEPS];
    logic [63:0]       r_rad  [1:SQ_STEPS];
    logic [33:0]       r_rem  [1:SQ_STEPS];
    logic [31:0]       r_root [1:SQ_STEPS];
    t_side             r_side [1:SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
        logic        c_vld;
        logic [63:0] c_rad;
        logic [33:0] c_rem;
        logic [31:0] c_root;
        t_side       c_side;
        logic [35:0] w_sh;
        logic [35:0] w_tr;

        if (k == 0) begin : g_first
            assign c_vld  = i_vld;
            assign c_rad  = i_rad;
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_side = i_side;
        end else begin : g_next
            assign c_vld  = r_vld[k];
            assign c_rad  = r_rad[k];
            assign c_rem  = r_rem[k];
            assign c_root = r_root[k];
            assign c_side = r_side[k];
        end

        // Bring down two radicand bits and try root*4+1.
        assign w_sh = {c_rem, c_rad[63:62]};
        assign w_tr = {2'b00, c_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {c_rad[61:0], 2'b00};
                r_side[k+1] <= c_side;
                if (w_sh >= w_tr) begin
                    r_rem[k+1]  <= 34'(w_sh - w_tr);
                    r_root[k+1] <= {c_root[30:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= w_sh[33:0];
                    r_root[k+1] <= {c_root[30:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_side     = r_side[SQ_STEPS];
        o_side.mag = r_root[SQ_STEPS];
    end
    assign o_vld = r_vld[SQ_STEPS];

endmodule
`default_nettype wire

// ----- hdl/vau_div.sv -----
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Depends on vau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vau_div
    import vau_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire t_side                  i_side,
    output logic                        o_vld,
    output t_side                       o_side,
    output logic [LANES-1:0][47:0]      o_quo
);

    logic                   r_vld  [1:DV_STEPS];
    logic [LANES-1:0][47:0] r_dvd  [1:DV_STEPS];   // dividend in, quotient shifts in
    logic [LANES-1:0][31:0] r_rem  [1:DV_STEPS];
    logic [31:0]            r_dvs  [1:DV_STEPS];
    t_side                  r_side [1:DV_STEPS];

    for (genvar k = 0; k < DV_STEPS; k++) begin : g_st
        logic                   c_vld;
        logic [LANES-1:0][47:0] c_dvd;
        logic [LANES-1:0][31:0] c_rem;
        logic [31:0]            c_dvs;
        t_side                  c_side;
        logic [LANES-1:0][47:0] n_dvd;
        logic [LANES-1:0][31:0] n_rem;

        if (k == 0) begin : g_first
            assign c_vld  = i_vld;
            assign c_rem  = '0;
            assign c_side = i_side;
            // Normalise divides by the length, the rest by the scalar.
            assign c_dvs  = (i_side.cmd == CMD_NORM) ? i_side.mag : i_side.abs_s;
            for (genvar l = 0; l < LANES; l++) begin : g_ld
                assign c_dvd[l] = {i_side.abs_a[l], 16'h0000};
            end
        end else begin : g_next
            assign c_vld  = r_vld[k];
            assign c_dvd  = r_dvd[k];
            assign c_rem  = r_rem[k];
            assign c_dvs  = r_dvs[k];
            assign c_side = r_side[k];
        end

        always_comb begin
            logic [32:0] sh;
            for (int l = 0; l < LANES; l++) begin
                sh = {c_rem[l], c_dvd[l][47]};
                if (sh >= {1'b0, c_dvs}) begin
                    n_rem[l] = 32'(sh - {1'b0, c_dvs});
                    n_dvd[l] = {c_dvd[l][46:0], 1'b1};
                end else begin
                    n_rem[l] = sh[31:0];
                    n_dvd[l] = {c_dvd[l][46:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= c_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvd[k+1]  <= n_dvd;
                r_rem[k+1]  <= n_rem;
                r_dvs[k+1]  <= c_dvs;
                r_side[k+1] <= c_side;
            end
        end
    end

    assign o_vld  = r_vld[DV_STEPS];
    assign o_side = r_side[DV_STEPS];
    assign o_quo  = r_dvd[DV_STEPS];

endmodule
`default_nettype wire

// ----- hdl/vector_arith_unit_core.sv -----
// Vector arithmetic unit, Q16.16: magnitude, normalise, add, sub, negate, scale, divide.
// Every request takes one path from request to result: 2 front stages, 32 root stages,
// 48 divider stages and the output register.
// Throughput one request per cycle; the whole pipeline holds while a result waits.
// Synchronous active-low reset clears every valid bit; data registers keep their contents.
// Depends on vau_pkg, vau_ifs, vau_sqrt and vau_div.
`timescale 1ns / 1ps
`default_nettype none
module vector_arith_unit_core
    import vau_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vau_in_if.sink     i_in,
    vau_out_if.source  o_out
);

    // Advance everything unless a finished result is still waiting.
    logic w_en;
    logic r_out_vld;
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // ---------------- stage 1: operand prep, squares and products -------------
    logic signed [LANES-1:0][31:0] w_a;
    logic signed [LANES-1:0][31:0] w_b;
    logic [LANES-1:0][31:0]        w_abs_a;
    logic [31:0]                   w_abs_s;
    logic [LANES-1:0][32:0]        w_sum;

    always_comb begin
        w_a[0] = i_in.ax;
        w_a[1] = i_in.ay;
        w_a[2] = i_in.three_d ? i_in.az : 32'sd0;   // drop z for 2D
        w_b[0] = i_in.bx;
        w_b[1] = i_in.by;
        w_b[2] = i_in.three_d ? i_in.bz : 32'sd0;
        w_abs_s = i_in.scalar[31] ? 32'(32'd0 - i_in.scalar) : i_in.scalar;
        for (int l = 0; l < LANES; l++) begin
            w_abs_a[l] = w_a[l][31] ? 32'(32'd0 - w_a[l]) : w_a[l];
            case (t_cmd'(i_in.cmd))
                CMD_ADD: w_sum[l] = {w_a[l][31], w_a[l]} + {w_b[l][31], w_b[l]};
                CMD_SUB: w_sum[l] = {w_a[l][31], w_a[l]} - {w_b[l][31], w_b[l]};
                default: w_sum[l] = 33'd0 - {w_a[l][31], w_a[l]};
            endcase
        end
    end

    logic                   r_s1_vld;
    t_side                  r_s1_side;
    logic [LANES-1:0][63:0] r_s1_sq;
    logic [LANES-1:0][63:0] r_s1_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side.cmd   <= t_cmd'(i_in.cmd);
            r_s1_side.neg_s <= i_in.scalar[31];
            r_s1_side.abs_s <= w_abs_s;
            r_s1_side.abs_a <= w_abs_a;
            r_s1_side.sum   <= w_sum;
            r_s1_side.prod  <= '0;
            r_s1_side.mag   <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_s1_side.neg_a[l] <= w_a[l][31];
                r_s1_sq[l]   <= w_abs_a[l] * w_abs_a[l];
                r_s1_prod[l] <= w_abs_a[l] * w_abs_s;
            end
        end
    end

    // ---------------- stage 2: sum of squares, scale products ----------------
    logic        r_s2_vld;
    t_side       r_s2_side;
    logic [63:0] r_s2_rad;
    t_side       w_s2_side;

    // Fold the scaled products into the side data.
    always_comb begin
        w_s2_side = r_s1_side;
        for (int l = 0; l < LANES; l++) begin
            w_s2_side.prod[l] = r_s1_prod[l][63:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_rad  <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
            r_s2_side <= w_s2_side;
        end
    end

    // ---------------- root and divide pipelines ------------------------------
    logic                   w_sq_vld;
    t_side                  w_sq_side;
    logic                   w_dv_vld;
    t_side                  w_dv_side;
    logic [LANES-1:0][47:0] w_quo;

    vau_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_rad   (r_s2_rad),
        .i_side  (r_s2_side),
        .o_vld   (w_sq_vld),
        .o_side  (w_sq_side)
    );

    vau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_side  (w_sq_side),
        .o_vld   (w_dv_vld),
        .o_side  (w_dv_side),
        .o_quo   (w_quo)
    );

    // ---------------- result select, saturate and output register ------------
    logic [LANES-1:0][31:0] n_res;
    logic [31:0]            n_mag;
    logic                   n_dz;
    logic                   n_sat;

    always_comb begin
        t_clamp      cl;
        logic [32:0] sabs;
        n_res = '0;
        n_mag = '0;
        n_dz  = 1'b0;
        n_sat = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            cl   = '0;
            sabs = w_dv_side.sum[l][32] ? 33'(33'd0 - w_dv_side.sum[l])
                                        : w_dv_side.sum[l];
            unique case (w_dv_side.cmd)
                CMD_MAG: begin
                    n_mag = w_dv_side.mag;
                end
                CMD_NORM: begin
                    n_mag = w_dv_side.mag;
                    n_dz  = (w_dv_side.mag == 32'd0);
                    cl    = clamp_sm(w_dv_side.neg_a[l], w_quo[l]);
                end
                CMD_ADD, CMD_SUB, CMD_NEG: begin
                    cl = clamp_sm(w_dv_side.sum[l][32], {15'd0, sabs});
                end
                CMD_MUL: begin
                    cl = clamp_sm(w_dv_side.neg_a[l] ^ w_dv_side.neg_s,
                                  w_dv_side.prod[l]);
                end
                CMD_DIV: begin
                    n_dz = (w_dv_side.abs_s == 32'd0);
                    cl   = clamp_sm(w_dv_side.neg_a[l] ^ w_dv_side.neg_s, w_quo[l]);
                end
                default: begin
                    cl = '0;
                end
            endcase
            // Drop lane results when the divisor was zero.
            if (!n_dz) begin
                n_res[l] = cl.val;
                n_sat    = n_sat | cl.sat;
            end
        end
    end

    logic [LANES-1:0][31:0] r_res;
    logic [31:0]            r_mag;
    logic                   r_dz;
    logic                   r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
            r_mag <= n_mag;
            r_dz  <= n_dz;
            r_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.rx        = r_res[0];
    assign o_out.ry        = r_res[1];
    assign o_out.rz        = r_res[2];
    assign o_out.magnitude = r_mag;
    assign o_out.div_zero  = r_dz;
    assign o_out.saturated = r_sat;

endmodule
`default_nettype wire

// ----- hdl/vau_chk.sv -----
// Port-level checks for the vector arithmetic unit, bound to the top level.
// Depends on vector_arith_unit_core_macros.svh and vector_arith_unit_core.
`timescale 1ns / 1ps
`default_nettype none
`include "vector_arith_unit_core_macros.svh"
module vau_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_rx,
    input wire logic [31:0] i_ry,
    input wire logic [31:0] i_rz,
    input wire logic        i_div_zero,
    input wire logic        i_saturated
);

    // Hold a result until it is taken.
    `VAU_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // A zero divisor yields zero components.
    `VAU_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, i_out_valid && i_div_zero, (i_rx | i_ry | i_rz) == '0)
    // A zero divisor never clamps.
    `VAU_ASSERT_IMP(a_dz_nosat, i_clk, i_rst_n, i_out_valid && i_div_zero, !i_saturated)
    // Requests are refused only while a result waits.
    `VAU_ASSERT_IMP(a_ready, i_clk, i_rst_n, !i_in_ready, i_out_valid && !i_out_ready)

endmodule

bind vector_arith_unit_core vau_chk u_vau_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_rx        (o_out.rx),
    .i_ry        (o_out.ry),
    .i_rz        (o_out.rz),
    .i_div_zero  (o_out.div_zero),
    .i_saturated (o_out.saturated)
);
`default_nettype wire

// ----- tb/vector_arith_unit_core_test.sv -----
// Self-checking bench for the vector arithmetic unit: directed table then random requests.
// Depends on vau_pkg, vau_ifs and the unit's RTL.
`timescale 1ns / 1ps
`default_nettype none
module vector_arith_unit_core_test
    import vau_pkg::*;
();

    typedef struct {
        t_cmd        cmd;
        logic        three_d;
        logic [31:0] ax, ay, az, bx, by, bz, s;
    } t_req;

    typedef struct {
        logic [31:0] rx, ry, rz, mag;
        logic        dz, sat;
    } t_res;

    typedef struct {
        t_req req;
        logic known;   // expected result typed into the table
        t_res res;
    } t_row;

    localparam int LATENCY    = 83;
    localparam int N_RANDOM   = 1530;
    localparam int CYCLE_CAP  = 400000;

    logic i_clk;
    logic i_rst_n;
    vau_in_if  req_if ();
    vau_out_if res_if ();

    vector_arith_unit_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    t_res        expected_q[$];
    int          mismatches = 0;
    int unsigned idle_pct_in = 0;
    int unsigned stall_pct_out = 0;
    longint      cycles = 0;

    // Saturate a signed sign-magnitude value to 32 bits.
    function automatic logic [31:0] sat32(input logic neg, input logic [79:0] m,
                                          inout logic sat);
        if (!neg) begin
            if (m > 80'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return m[31:0];
        end
        if (m > 80'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(80'd0 - m);
    endfunction

    function automatic logic [63:0] mag_abs(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Work out the unit's answer for one request.
    function automatic t_res vector_result(input t_req q);
        t_res        o;
        logic signed [63:0] a[3], b[3], s;
        logic [31:0] r[3];
        logic [63:0] acc;
        int          n;
        logic        sat;
        sat = 1'b0;
        o = '{default: 0};
        r = '{0, 0, 0};
        n = q.three_d ? 3 : 2;
        a[0] = signed'(q.ax); a[1] = signed'(q.ay); a[2] = signed'(q.az);
        b[0] = signed'(q.bx); b[1] = signed'(q.by); b[2] = signed'(q.bz);
        if (!q.three_d) begin
            a[2] = 0;
            b[2] = 0;
        end
        s = signed'(q.s);
        case (q.cmd)
            CMD_MAG, CMD_NORM: begin
                acc = 0;
                for (int i = 0; i < n; i++) acc += mag_abs(a[i]) * mag_abs(a[i]);
                o.mag = 32'(root64(acc));
                if (q.cmd == CMD_NORM) begin
                    if (o.mag == 0) o.dz = 1'b1;
                    else for (int i = 0; i < n; i++)
                        r[i] = sat32(a[i] < 0, 80'((mag_abs(a[i]) << 16) / o.mag), sat);
                end
            end
            CMD_ADD: for (int i = 0; i < n; i++)
                r[i] = sat32(a[i] + b[i] < 0, 80'(mag_abs(a[i] + b[i])), sat);
            CMD_SUB: for (int i = 0; i < n; i++)
                r[i] = sat32(a[i] - b[i] < 0, 80'(mag_abs(a[i] - b[i])), sat);
            CMD_NEG: for (int i = 0; i < n; i++)
                r[i] = sat32(a[i] > 0, 80'(mag_abs(a[i])), sat);
            CMD_MUL: for (int i = 0; i < n; i++)
                r[i] = sat32((a[i] < 0) != (s < 0),
                             80'((mag_abs(a[i]) * mag_abs(s)) >> 16), sat);
            CMD_DIV: begin
                if (s == 0) o.dz = 1'b1;
                else for (int i = 0; i < n; i++)
                    r[i] = sat32((a[i] < 0) != (s < 0),
                                 80'((mag_abs(a[i]) << 16) / mag_abs(s)), sat);
            end
            default: ;
        endcase
        o.rx = r[0]; o.ry = r[1]; o.rz = r[2];
        o.sat = sat;
        return o;
    endfunction

    // Directed table: extremes, each operation and every special case.
    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    t_row rows[$];

    function automatic t_row row(input t_cmd c, input int t3, input logic [31:0] ax,
                                 ay, az, bx, by, bz, s, input int k,
                                 input t_res e);
        t_row w;
        w.req = '{c, 1'(t3), ax, ay, az, bx, by, bz, s};
        w.known = 1'(k);
        w.res = e;
        return w;
    endfunction

    initial begin
        t_res z;
        z = '{default: 0};
        rows.push_back(row(CMD_MAG, 1, 0, 0, 0, 0, 0, 0, 0, 1, z));
        rows.push_back(row(CMD_MAG, 1, ONE, 0, 0, 0, 0, 0, 0, 1,
                           '{0, 0, 0, ONE, 1'b0, 1'b0}));
        rows.push_back(row(CMD_MAG, 1, MINN, MINN, MINN, 0, 0, 0, 0, 0, z));
        rows.push_back(row(CMD_MAG, 0, MAXP, MAXP, MAXP, 0, 0, 0, 0, 0, z));
        rows.push_back(row(CMD_NORM, 1, 0, 0, 0, 5, 5, 5, 5, 1,
                           '{0, 0, 0, 0, 1'b1, 1'b0}));
        rows.push_back(row(CMD_NORM, 0, 0, 0, MAXP, 0, 0, 0, 0, 1,
                           '{0, 0, 0, 0, 1'b1, 1'b0}));
        rows.push_back(row(CMD_NORM, 1, MINN, 0, 0, 0, 0, 0, 0, 0, z));
        rows.push_back(row(CMD_NORM, 1, 3 * ONE, -4 * ONE, MAXP, 0, 0, 0, 0, 0, z));
        rows.push_back(row(CMD_ADD, 1, MAXP, MINN, 1, 1, MINN, MAXP, 0, 1,
                           '{MAXP, MINN, MAXP, 0, 1'b0, 1'b1}));
        rows.push_back(row(CMD_ADD, 0, 2, 3, 7, 5, 6, 7, 0, 1,
                           '{7, 9, 0, 0, 1'b0, 1'b0}));
        rows.push_back(row(CMD_SUB, 1, MINN, MAXP, 0, 1, MINN, MINN, 0, 1,
                           '{MINN, MAXP, MAXP, 0, 1'b0, 1'b1}));
        rows.push_back(row(CMD_NEG, 1, MINN, MAXP, 0, 0, 0, 0, 0, 1,
                           '{MAXP, MINN + 1, 0, 0, 1'b0, 1'b1}));
        rows.push_back(row(CMD_NEG, 0, 5, 0, MINN, 0, 0, 0, 0, 1,
                           '{-5, 0, 0, 0, 1'b0, 1'b0}));
        rows.push_back(row(CMD_MUL, 1, MAXP, MINN, ONE, 0, 0, 0, MAXP, 1,
                           '{MAXP, MINN, MAXP, 0, 1'b0, 1'b1}));
        rows.push_back(row(CMD_MUL, 1, MINN, 7, -7, 0, 0, 0, MINN, 0, z));
        rows.push_back(row(CMD_MUL, 0, 3, -3, 9, 0, 0, 0, ONE, 0, z));
        rows.push_back(row(CMD_DIV, 1, 5, 6, 7, 0, 0, 0, 0, 1,
                           '{0, 0, 0, 0, 1'b1, 1'b0}));
        rows.push_back(row(CMD_DIV, 1, MAXP, MINN, 1, 0, 0, 0, 1, 0, z));
        rows.push_back(row(CMD_DIV, 1, MINN, MINN, MAXP, 0, 0, 0, MINN, 0, z));
        rows.push_back(row(CMD_DIV, 0, -ONE, ONE, 4, 0, 0, 0, -1, 0, z));
        rows.push_back(row(CMD_NONE, 1, MAXP, MINN, 5, 6, 7, 8, 9, 1, z));
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return MAXP;
            1: return MINN;
            2: return 32'($urandom_range(0, 8)) - 32'd4;
            3: return 32'(signed'($urandom_range(0, 65535 * 2)) - 65535) << 4;
            4: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_req rand_req();
        t_req q;
        q.cmd = ($urandom_range(0, 15) == 0) ? CMD_NONE : t_cmd'($urandom_range(0, 6));
        q.three_d = 1'($urandom_range(0, 1));
        q.ax = rand_word(); q.ay = rand_word(); q.az = rand_word();
        q.bx = rand_word(); q.by = rand_word(); q.bz = rand_word();
        q.s  = rand_word();
        return q;
    endfunction

    // Hold the request on the channel until the unit takes it; drop valid while idling.
    task automatic send_req(input t_req q);
        while (idle_pct_in != 0 && $urandom_range(1, 100) <= idle_pct_in) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= q.cmd;
        req_if.three_d <= q.three_d;
        req_if.ax <= q.ax; req_if.ay <= q.ay; req_if.az <= q.az;
        req_if.bx <= q.bx; req_if.by <= q.by; req_if.bz <= q.bz;
        req_if.scalar <= q.s;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Receiver: stall at random, compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_res e;
        cycles <= cycles + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = expected_q.pop_front();
                if (res_if.rx !== e.rx || res_if.ry !== e.ry || res_if.rz !== e.rz ||
                    res_if.magnitude !== e.mag || res_if.div_zero !== e.dz ||
                    res_if.saturated !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                                 e.rx, e.ry, e.rz, e.mag, e.dz, e.sat, res_if.rx,
                                 res_if.ry, res_if.rz, res_if.magnitude,
                                 res_if.div_zero, res_if.saturated);
                end
            end
        end
        res_if.ready <= !(stall_pct_out != 0 && $urandom_range(1, 100) <= stall_pct_out);
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_req q;
        req_if.valid = 1'b0;
        req_if.cmd = '0; req_if.three_d = 1'b0;
        req_if.ax = '0; req_if.ay = '0; req_if.az = '0;
        req_if.bx = '0; req_if.by = '0; req_if.bz = '0;
        req_if.scalar = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: the typed answer where given, the predictor elsewhere.
        foreach (rows[i]) begin
            if (rows[i].known) expected_q.push_back(rows[i].res);
            else expected_q.push_back(vector_result(rows[i].req));
            send_req(rows[i].req);
        end

        // Random requests in four idling phases of equal length.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
                1: begin idle_pct_in = 75; stall_pct_out = 0;  end
                2: begin idle_pct_in = 0;  stall_pct_out = 75; end
                default: begin idle_pct_in = 8; stall_pct_out = 8; end
            endcase
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                // drop into a stretch without idling now and again
                if (k % 100 == 50) begin idle_pct_in = 0; stall_pct_out = 0; end
                if (k % 100 == 70) begin
                    idle_pct_in = ph == 1 ? 75 : ph == 3 ? 8 : 0;
                    stall_pct_out = ph == 2 ? 75 : ph == 3 ? 8 : 0;
                end
                q = rand_req();
                expected_q.push_back(vector_result(q));
                send_req(q);
            end
        end
        req_if.valid <= 1'b0;

        stall_pct_out = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
